@@ rtl/core/ppz_pkg.sv @@
// Shared constants and controller/datapath interface types for the point projection block.
package ppz_pkg;

    localparam logic [15:0] EMPTY_DEPTH = 16'hFFFF;
    localparam logic [15:0] MAX_DEPTH   = 16'hFFFE;

    localparam int Q_W    = 13;
    localparam int NUM_W  = 35;
    localparam int DSH_W  = 16 + Q_W - 1;
    localparam int IN_W   = 72;
    localparam int OUT_W  = 56;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] CFG_SCALE_X  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_SCALE_Y  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_SCALE_Z  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_OFFSET_X = 3'd3;
    localparam logic [IDX_W-1:0] CFG_OFFSET_Y = 3'd4;
    localparam logic [IDX_W-1:0] CFG_FOCAL_X  = 3'd5;
    localparam logic [IDX_W-1:0] CFG_FOCAL_Y  = 3'd6;
    localparam logic [IDX_W-1:0] CFG_CENTER   = 3'd7;

    typedef struct packed {
        logic load;
        logic scale;
        logic mm;
        logic prod;
        logic num;
        logic addr;
        logic read;
        logic write;
        logic clear_step;
        logic emit;
    } ppz_cmd_t;

    typedef struct packed {
        logic kind;
        logic invalid;
        logic z_zero;
        logic in_frame;
        logic div_done;
        logic clear_last;
        logic out_free;
    } ppz_status_t;

endpackage

@@ rtl/core/ppz_div.sv @@
// Restoring divider that yields a short quotient and flags a quotient too large for it.
module ppz_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ppz_pkg::NUM_W-1:0]  numer,
    input  logic [15:0]                divisor,
    output logic                       busy,
    output logic [ppz_pkg::Q_W-1:0]    quot,
    output logic                       ovf
);
    import ppz_pkg::*;

    logic [NUM_W-1:0] rem_reg;
    logic [DSH_W-1:0] dsh_reg;
    logic [Q_W-1:0]   quot_reg;
    logic             ovf_reg;
    logic             busy_reg;
    logic [3:0]       cnt_reg;
    logic             ge;

    assign ge = rem_reg >= NUM_W'(dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 4'(Q_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= numer;
            dsh_reg  <= {divisor, (Q_W-1)'(0)};
            quot_reg <= '0;
            ovf_reg  <= numer >= NUM_W'({divisor, Q_W'(0)});
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - NUM_W'(dsh_reg);
            end
            quot_reg <= {quot_reg[Q_W-2:0], ge};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;
    assign ovf  = ovf_reg;

endmodule

@@ rtl/core/ppz_ctrl.sv @@
// Controller state machine that sequences the projection datapath.
module ppz_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  ppz_pkg::ppz_status_t status,
    output ppz_pkg::ppz_cmd_t    cmd
);
    import ppz_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCALE,
        ST_MM,
        ST_PROD,
        ST_NUM,
        ST_DIV,
        ST_ADDR,
        ST_READ,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    if (status.clear_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    if (status.kind)
                    begin
                        state_reg <= ST_ADDR;
                    end
                    else if (status.invalid)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_MM;
                    end
                end
                ST_MM:
                begin
                    state_reg <= ST_PROD;
                end
                ST_PROD:
                begin
                    state_reg <= status.z_zero ? ST_DONE : ST_NUM;
                end
                ST_NUM:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (status.div_done)
                    begin
                        state_reg <= ST_ADDR;
                    end
                end
                ST_ADDR:
                begin
                    state_reg <= status.in_frame ? ST_READ : ST_DONE;
                end
                ST_READ:
                begin
                    state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (status.out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd            = '0;
        cmd.load       = (state_reg == ST_IDLE) && s_axis_tvalid;
        cmd.scale      = (state_reg == ST_SCALE);
        cmd.mm         = (state_reg == ST_MM);
        cmd.prod       = (state_reg == ST_PROD);
        cmd.num        = (state_reg == ST_NUM);
        cmd.addr       = (state_reg == ST_ADDR);
        cmd.read       = (state_reg == ST_READ);
        cmd.write      = (state_reg == ST_WRITE);
        cmd.clear_step = (state_reg == ST_CLEAR);
        cmd.emit       = (state_reg == ST_DONE) && status.out_free;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

endmodule

@@ rtl/core/ppz_datapath.sv @@
// Datapath with configuration registers, projection arithmetic, depth store and output register.
module ppz_datapath #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ppz_pkg::ppz_cmd_t           cmd,
    output ppz_pkg::ppz_status_t        status,
    input  logic [ppz_pkg::IN_W-1:0]    s_axis_tdata,
    input  logic                        s_axis_tuser,
    input  logic                        cfg_valid,
    input  logic [ppz_pkg::IDX_W-1:0]   cfg_index,
    input  logic [31:0]                 cfg_data,
    input  logic                        m_axis_tready,
    output logic                        m_axis_tvalid,
    output logic [ppz_pkg::OUT_W-1:0]   m_axis_tdata
);
    import ppz_pkg::*;

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [15:0]        scale_x_reg, scale_y_reg, scale_z_reg;
    logic signed [19:0] offset_x_reg, offset_y_reg;
    logic [23:0]        focal_x_reg, focal_y_reg;
    logic [31:0]        center_reg;

    logic               kind_reg;
    logic [15:0]        ra_reg, rb_reg, rc_reg;
    logic [9:0]         col_reg;
    logic [8:0]         row_reg;

    logic [31:0]        px_reg, py_reg, pz_reg;
    logic signed [15:0] x_mm_reg, y_mm_reg;
    logic [15:0]        z_mm_reg;
    logic signed [40:0] fx_reg, fy_reg;
    logic [31:0]        cx_reg, cy_reg;
    logic               neg_u_reg, neg_v_reg;

    logic [AW-1:0]      addr_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic [15:0]        rd_data_reg;

    logic [15:0]        raster_reg, map_reg;
    logic               pvalid_reg, hit_reg;
    logic [9:0]         pcol_reg;
    logic [8:0]         prow_reg;

    logic               m_valid_reg;
    logic [OUT_W-1:0]   m_data_reg;

    logic [15:0]        mem [DEPTH];

    function automatic logic signed [15:0] to_mm(input logic [31:0] p,
                                                 input logic signed [19:0] off);
        logic signed [33:0] s;
        logic signed [33:0] adj;
        logic signed [21:0] q;
        s   = $signed({2'b00, p}) + (34'(off) <<< 8);
        adj = s[33] ? s + 34'sd4095 : s;
        q   = 22'(adj >>> 12);
        if (q > 22'sd32767)
        begin
            to_mm = 16'sh7FFF;
        end
        else if (q < -22'sd32768)
        begin
            to_mm = 16'sh8000;
        end
        else
        begin
            to_mm = q[15:0];
        end
    endfunction

    logic [19:0]        z_trunc;
    logic [15:0]        z_next;
    logic signed [41:0] n_u, n_v;
    logic [41:0]        mag_u, mag_v;
    logic [42:0]        sum_u, sum_v;
    logic [Q_W-1:0]     q_u, q_v;
    logic               ovf_u, ovf_v, busy_u, busy_v;
    logic               u_ok, v_ok, pt_in, rd_in, in_frame;
    logic [Q_W-1:0]     sel_c, sel_r;
    logic [AW-1:0]      addr_next;
    logic               we;
    logic [AW-1:0]      wa;
    logic [15:0]        wd;

    assign z_trunc = pz_reg[31:12];
    assign z_next  = (z_trunc > 20'd65534) ? MAX_DEPTH : z_trunc[15:0];

    assign n_u   = 42'(fx_reg) + $signed({6'b0, cx_reg, 4'b0});
    assign n_v   = 42'(fy_reg) + $signed({6'b0, cy_reg, 4'b0});
    assign mag_u = n_u[41] ? 42'(-n_u) : 42'(n_u);
    assign mag_v = n_v[41] ? 42'(-n_v) : 42'(n_v);
    assign sum_u = 43'(mag_u) + 43'({z_mm_reg, 7'b0});
    assign sum_v = 43'(mag_v) + 43'({z_mm_reg, 7'b0});

    ppz_div u_div_u
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.num),
        .numer   (sum_u[42:8]),
        .divisor (z_mm_reg),
        .busy    (busy_u),
        .quot    (q_u),
        .ovf     (ovf_u)
    );

    ppz_div u_div_v
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.num),
        .numer   (sum_v[42:8]),
        .divisor (z_mm_reg),
        .busy    (busy_v),
        .quot    (q_v),
        .ovf     (ovf_v)
    );

    assign u_ok = !ovf_u && (!neg_u_reg || (q_u == '0)) && (q_u < Q_W'(FRAME_WIDTH));
    assign v_ok = !ovf_v && (!neg_v_reg || (q_v == '0)) && (q_v < Q_W'(FRAME_HEIGHT));
    assign pt_in = u_ok && v_ok;
    assign rd_in = (Q_W'(col_reg) < Q_W'(FRAME_WIDTH)) && (Q_W'(row_reg) < Q_W'(FRAME_HEIGHT));
    assign in_frame = kind_reg ? rd_in : pt_in;
    assign sel_c = kind_reg ? Q_W'(col_reg) : q_u;
    assign sel_r = kind_reg ? Q_W'(row_reg) : q_v;
    assign addr_next = AW'(AW'(sel_r) * AW'(FRAME_WIDTH)) + AW'(sel_c);

    assign we = cmd.clear_step || (cmd.write && (kind_reg || (rd_data_reg > z_mm_reg)));
    assign wa = cmd.clear_step ? clr_cnt_reg : addr_reg;
    assign wd = (cmd.clear_step || kind_reg) ? EMPTY_DEPTH : z_mm_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_x_reg  <= 16'd1024;
            scale_y_reg  <= 16'd1024;
            scale_z_reg  <= 16'd1024;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            focal_x_reg  <= 24'd128000;
            focal_y_reg  <= 24'd128000;
            center_reg   <= '0;
            clr_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_SCALE_X:  scale_x_reg  <= cfg_data[15:0];
                    CFG_SCALE_Y:  scale_y_reg  <= cfg_data[15:0];
                    CFG_SCALE_Z:  scale_z_reg  <= cfg_data[15:0];
                    CFG_OFFSET_X: offset_x_reg <= cfg_data[19:0];
                    CFG_OFFSET_Y: offset_y_reg <= cfg_data[19:0];
                    CFG_FOCAL_X:  focal_x_reg  <= cfg_data[23:0];
                    CFG_FOCAL_Y:  focal_y_reg  <= cfg_data[23:0];
                    CFG_CENTER:   center_reg   <= cfg_data;
                    default:      center_reg   <= center_reg;
                endcase
            end
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= s_axis_tuser;
            ra_reg     <= s_axis_tdata[15:0];
            rb_reg     <= s_axis_tdata[31:16];
            rc_reg     <= s_axis_tdata[47:32];
            col_reg    <= s_axis_tdata[57:48];
            row_reg    <= s_axis_tdata[66:58];
            raster_reg <= (!s_axis_tuser && (s_axis_tdata[47:32] == EMPTY_DEPTH)) ?
                          EMPTY_DEPTH : 16'd0;
            pvalid_reg <= 1'b0;
            hit_reg    <= 1'b0;
            pcol_reg   <= '0;
            prow_reg   <= '0;
            map_reg    <= '0;
        end
        if (cmd.scale)
        begin
            px_reg <= 32'(ra_reg) * 32'(scale_x_reg);
            py_reg <= 32'(rb_reg) * 32'(scale_y_reg);
            pz_reg <= 32'(rc_reg) * 32'(scale_z_reg);
        end
        if (cmd.mm)
        begin
            x_mm_reg   <= to_mm(px_reg, offset_x_reg);
            y_mm_reg   <= to_mm(py_reg, offset_y_reg);
            z_mm_reg   <= z_next;
            raster_reg <= z_next;
            pvalid_reg <= 1'b1;
        end
        if (cmd.prod)
        begin
            fx_reg <= 41'($signed({1'b0, focal_x_reg})) * 41'(x_mm_reg);
            fy_reg <= 41'($signed({1'b0, focal_y_reg})) * 41'(y_mm_reg);
            cx_reg <= 32'(center_reg[15:0]) * 32'(z_mm_reg);
            cy_reg <= 32'(center_reg[31:16]) * 32'(z_mm_reg);
        end
        if (cmd.num)
        begin
            neg_u_reg <= n_u[41];
            neg_v_reg <= n_v[41];
        end
        if (cmd.addr)
        begin
            addr_reg <= addr_next;
            if (!kind_reg && pt_in)
            begin
                hit_reg  <= 1'b1;
                pcol_reg <= q_u[9:0];
                prow_reg <= q_v[8:0];
            end
            if (kind_reg && !rd_in)
            begin
                map_reg <= EMPTY_DEPTH;
            end
        end
        if (cmd.write && kind_reg)
        begin
            map_reg <= rd_data_reg;
        end
        if (cmd.emit)
        begin
            m_data_reg <= {3'b000, map_reg, prow_reg, pcol_reg, hit_reg, pvalid_reg,
                           raster_reg};
        end
    end

    always_comb
    begin
        status            = '0;
        status.kind       = kind_reg;
        status.invalid    = (rc_reg == EMPTY_DEPTH);
        status.z_zero     = (z_mm_reg == 16'd0);
        status.in_frame   = in_frame;
        status.div_done   = !busy_u && !busy_v;
        status.clear_last = (clr_cnt_reg == AW'(DEPTH - 1));
        status.out_free   = !m_valid_reg || m_axis_tready;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

@@ rtl/core/point_projection_zbuffer.sv @@
// Top level of the pinhole point projection block with a z-buffered depth store.
//
// The input stream carries one item per transaction: tuser 0 is a point with raw
// A, B and C codes, tuser 1 reads one depth store entry and clears it to empty.
// Every item gives exactly one transaction on the output stream.
// Configuration registers are written over the cfg channel, which is always ready.
// A point passes through the two 13-step dividers that form the projected column
// and row side by side, then reads the depth store and writes it if closer.
// An invalid point, a zero depth or a point outside the frame finishes earlier.
// A readout passes from acceptance to output through one store read followed by
// one store write.
// Items are processed one at a time; a new item is accepted once the previous one
// has been placed in the output register.
// After reset the block sweeps all FRAME_WIDTH * FRAME_HEIGHT depth store entries
// to empty, one entry per cycle, before it accepts its first item.
// A stalled receiver holds the result in the output register; the next item is
// still taken in and processed, then waits until that register frees up.
module point_projection_zbuffer #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // raw_a, raw_b, raw_c, read_col, read_row, zero pad
    input  logic [ppz_pkg::IN_W-1:0]    s_axis_tdata,
    // kind
    input  logic                        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // raster_depth, point_valid, proj_hit, proj_col, proj_row, map_depth, zero pad
    output logic [ppz_pkg::OUT_W-1:0]   m_axis_tdata,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ppz_pkg::IDX_W-1:0]   cfg_index,
    input  logic [31:0]                 cfg_data
);
    import ppz_pkg::*;

    ppz_cmd_t    cmd;
    ppz_status_t status;

    assign cfg_ready = 1'b1;

    ppz_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    ppz_datapath #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

@@ dv/ppz_tb_pkg.sv @@
// Item kinds and the result layout shared by the point projection testbench files.
`timescale 1ns / 1ps
package ppz_tb_pkg;

    typedef enum logic {
        KIND_POINT   = 1'b0,
        KIND_READOUT = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic [15:0] map_depth;
        logic [8:0]  proj_row;
        logic [9:0]  proj_col;
        logic        proj_hit;
        logic        point_valid;
        logic [15:0] raster_depth;
    } depth_result_t;

endpackage

@@ dv/point_projection_zbuffer_checker.sv @@
// Checker that predicts every point projection result and compares it with the output stream.
`timescale 1ns / 1ps
module point_projection_zbuffer_checker #(
    parameter int FRAME_W = 640,
    parameter int FRAME_H = 480
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [ppz_pkg::IN_W-1:0]    s_axis_tdata,
    input  logic                        s_axis_tuser,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [ppz_pkg::OUT_W-1:0]   m_axis_tdata,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [ppz_pkg::IDX_W-1:0]   cfg_index,
    input  logic [31:0]                 cfg_data,
    output int                          fail_count,
    output int                          pending
);
    import ppz_pkg::*;
    import ppz_tb_pkg::*;

    logic [15:0] depth_map [0:FRAME_W*FRAME_H-1];
    logic [15:0] sc_x, sc_y, sc_z;
    logic [19:0] off_x, off_y;
    logic [23:0] foc_x, foc_y;
    logic [31:0] center;
    depth_result_t expected_q [$];

    initial
    begin
        for (int i = 0; i < FRAME_W*FRAME_H; i++)
            depth_map[i] = EMPTY_DEPTH;
    end

    function automatic longint to_mm(logic [15:0] raw, logic [15:0] sc, logic [19:0] off);
        longint s;
        longint o;
        o = longint'($signed(off));
        s = (longint'(raw) * longint'(sc) + o * 256) / 4096;
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        return s;
    endfunction

    function automatic longint project_axis(logic [23:0] f, longint pos, logic [15:0] c,
                                            longint z);
        longint n;
        longint d;
        n = longint'(f) * pos + longint'(c) * 16 * z;
        d = z * 256;
        if (n >= 0)
            return (2 * n + d) / (2 * d);
        return -((-2 * n + d) / (2 * d));
    endfunction

    task automatic predict_depth(input logic kind, input logic [IN_W-1:0] d,
                                 output depth_result_t r);
        longint zs;
        longint x;
        longint y;
        longint u;
        longint v;
        int idx;
        r = '0;
        if (kind == KIND_READOUT)
        begin
            if (d[57:48] < FRAME_W && d[66:58] < FRAME_H)
            begin
                idx = int'(d[66:58]) * FRAME_W + int'(d[57:48]);
                r.map_depth = depth_map[idx];
                depth_map[idx] = EMPTY_DEPTH;
            end
            else
                r.map_depth = EMPTY_DEPTH;
        end
        else if (d[47:32] == 16'hFFFF)
            r.raster_depth = EMPTY_DEPTH;
        else
        begin
            zs = (longint'(d[47:32]) * longint'(sc_z)) >>> 12;
            if (zs > 65534)
                zs = 65534;
            r.raster_depth = zs[15:0];
            r.point_valid = 1'b1;
            if (zs != 0)
            begin
                x = to_mm(d[15:0], sc_x, off_x);
                y = to_mm(d[31:16], sc_y, off_y);
                u = project_axis(foc_x, x, center[15:0], zs);
                v = project_axis(foc_y, y, center[31:16], zs);
                if (u >= 0 && u < FRAME_W && v >= 0 && v < FRAME_H)
                begin
                    idx = int'(v) * FRAME_W + int'(u);
                    if (depth_map[idx] > zs[15:0])
                        depth_map[idx] = zs[15:0];
                    r.proj_hit = 1'b1;
                    r.proj_col = u[9:0];
                    r.proj_row = v[8:0];
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        depth_result_t exp_r;
        depth_result_t got;
        if (!rst_n)
        begin
            sc_x = 16'd1024;
            sc_y = 16'd1024;
            sc_z = 16'd1024;
            off_x = '0;
            off_y = '0;
            foc_x = 24'd128000;
            foc_y = 24'd128000;
            center = '0;
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[52:0];
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (got.raster_depth !== exp_r.raster_depth
                        || got.point_valid !== exp_r.point_valid
                        || got.proj_hit !== exp_r.proj_hit
                        || got.proj_col !== exp_r.proj_col
                        || got.proj_row !== exp_r.proj_row
                        || got.map_depth !== exp_r.map_depth)
                    begin
                        $display({"%0t: mismatch expected depth=%0d valid=%0d hit=%0d",
                                  " col=%0d row=%0d map=%0d"},
                                 $time, exp_r.raster_depth, exp_r.point_valid,
                                 exp_r.proj_hit, exp_r.proj_col, exp_r.proj_row,
                                 exp_r.map_depth);
                        $display({"%0t:          actual   depth=%0d valid=%0d hit=%0d",
                                  " col=%0d row=%0d map=%0d"},
                                 $time, got.raster_depth, got.point_valid, got.proj_hit,
                                 got.proj_col, got.proj_row, got.map_depth);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SCALE_X:  sc_x = cfg_data[15:0];
                    CFG_SCALE_Y:  sc_y = cfg_data[15:0];
                    CFG_SCALE_Z:  sc_z = cfg_data[15:0];
                    CFG_OFFSET_X: off_x = cfg_data[19:0];
                    CFG_OFFSET_Y: off_y = cfg_data[19:0];
                    CFG_FOCAL_X:  foc_x = cfg_data[23:0];
                    CFG_FOCAL_Y:  foc_y = cfg_data[23:0];
                    CFG_CENTER:   center = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_depth(s_axis_tuser, s_axis_tdata, exp_r);
                expected_q.push_back(exp_r);
            end
            pending = expected_q.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
// Top of the point projection testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps
module testbench;
    import ppz_pkg::*;
    import ppz_tb_pkg::*;

    localparam int IDLE_LIMIT = 1200000;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;
    logic               s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index;
    logic [31:0]        cfg_data;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles = 0;
    int                 stall_left;
    logic [18:0]        hit_spots [$];

    point_projection_zbuffer u_dut (.*);

    point_projection_zbuffer_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = rand_gap();
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready && m_axis_tdata[17])
        begin
            hit_spots.push_back({m_axis_tdata[36:28], m_axis_tdata[27:18]});
            if (hit_spots.size() > 64)
                void'(hit_spots.pop_front());
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** point_projection_zbuffer: FAILED **");
            $finish;
        end
    end

    task automatic send_item(input item_kind_t kind, input logic [IN_W-1:0] data,
                             input int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= data;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_point(input logic [15:0] a, input logic [15:0] b,
                              input logic [15:0] c);
        send_item(KIND_POINT, {24'd0, c, b, a}, rand_gap());
    endtask

    task automatic send_readout(input logic [9:0] col, input logic [8:0] row);
        send_item(KIND_READOUT, {5'd0, row, col, 48'd0}, rand_gap());
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_camera(input logic [15:0] sx, input logic [15:0] sy,
                               input logic [15:0] sz,
                               input logic [19:0] ox, input logic [19:0] oy,
                               input logic [23:0] fx, input logic [23:0] fy,
                               input logic [31:0] ctr);
        drain();
        write_reg(CFG_SCALE_X, {16'd0, sx});
        write_reg(CFG_SCALE_Y, {16'd0, sy});
        write_reg(CFG_SCALE_Z, {16'd0, sz});
        write_reg(CFG_OFFSET_X, {{12{ox[19]}}, ox});
        write_reg(CFG_OFFSET_Y, {{12{oy[19]}}, oy});
        write_reg(CFG_FOCAL_X, {8'd0, fx});
        write_reg(CFG_FOCAL_Y, {8'd0, fy});
        write_reg(CFG_CENTER, ctr);
    endtask

    task automatic run_random(input int count);
        int r;
        logic [15:0] c;
        logic [18:0] spot;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 18)
            begin
                if (hit_spots.size() > 0 && $urandom_range(0, 1) == 1)
                begin
                    spot = hit_spots[$urandom_range(0, hit_spots.size() - 1)];
                    send_readout(spot[9:0], spot[18:10]);
                end
                else
                    send_readout(10'($urandom_range(0, 1023)), 9'($urandom_range(0, 511)));
            end
            else if (r < 35)
            begin
                c = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom());
                send_point(16'($urandom()), 16'($urandom()), c);
            end
            else
            begin
                c = 16'($urandom_range(400, 60000));
                send_point(16'($urandom_range(0, c / 3)), 16'($urandom_range(0, c / 3)), c);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_POINT;
        cfg_valid = 1'b0;
        cfg_index = CFG_SCALE_X;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_readout(10'd0, 9'd0);
        send_readout(10'd639, 9'd479);
        send_readout(10'd640, 9'd0);
        send_readout(10'd0, 9'd480);
        send_readout(10'd1023, 9'd511);
        send_point(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_point(16'd100, 16'd100, 16'd0);
        send_point(16'd100, 16'd100, 16'd3);
        send_point(16'd0, 16'd0, 16'd4000);
        send_point(16'd0, 16'd0, 16'd2000);
        send_point(16'd0, 16'd0, 16'd8000);
        send_readout(10'd0, 9'd0);
        send_readout(10'd0, 9'd0);
        send_point(16'd4, 16'd4, 16'd4);
        send_point(16'hFFFF, 16'hFFFF, 16'hFFFE);
        send_point(16'd1000, 16'd100, 16'd2000);
        send_point(16'd1, 16'd2000, 16'd3000);
        send_point(16'hFFFF, 16'h0000, 16'h0001);

        load_camera(16'd1024, 16'd1024, 16'd1024, 20'd0, 20'd0, 24'd128000, 24'd128000,
                    {16'd3840, 16'd5120});
        run_random(110);
        load_camera(16'd1024, 16'd1024, 16'd1024, -20'sd32000, -20'sd24000, 24'd128000,
                    24'd128000, {16'd3840, 16'd5120});
        run_random(110);
        load_camera(16'hFFFF, 16'h0000, 16'hFFFF, 20'h7FFFF, 20'h80000, 24'hFFFFFF,
                    24'h000000, 32'hFFFFFFFF);
        send_point(16'hFFFF, 16'hFFFF, 16'hFFFE);
        run_random(100);
        load_camera(16'h0000, 16'hFFFF, 16'h0000, 20'h80000, 20'h7FFFF, 24'h000000,
                    24'hFFFFFF, 32'h00000000);
        run_random(100);
        load_camera(16'($urandom_range(512, 4096)), 16'($urandom_range(512, 4096)),
                    16'($urandom_range(512, 8192)),
                    20'($urandom_range(0, 32000)), 20'($urandom_range(0, 32000)),
                    24'($urandom_range(40000, 300000)), 24'($urandom_range(40000, 300000)),
                    {16'($urandom_range(0, 7680)), 16'($urandom_range(0, 10240))});
        run_random(110);
        load_camera(16'd1024, 16'd1024, 16'd4096, 20'd0, 20'd0, 24'd64000, 24'd64000,
                    {16'd3840, 16'd5120});
        run_random(110);

        drain();
        if (fail_count == 0)
            $display("** point_projection_zbuffer: PASSED **");
        else
            $display("** point_projection_zbuffer: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/ppz_pkg.sv
rtl/core/ppz_div.sv
rtl/core/ppz_ctrl.sv
rtl/core/ppz_datapath.sv
rtl/core/point_projection_zbuffer.sv
dv/ppz_tb_pkg.sv
dv/point_projection_zbuffer_checker.sv
dv/testbench.sv
